FILE: src/multiplexed_servo_pulse_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Servo sequencer assertion macros
// Shared concurrent assertion shorthands, all clocked on the rising edge and
// muted while reset is held.
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_SERVO_PULSE_SEQUENCER_MACROS_SVH
`define MULTIPLEXED_SERVO_PULSE_SEQUENCER_MACROS_SVH

// Condition that must hold at every edge
`define MSPS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("servo sequencer invariant violated");

// Antecedent implies consequent in the same cycle
`define MSPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("servo sequencer same-cycle check failed");

// Antecedent implies consequent in the next cycle
`define MSPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("servo sequencer next-cycle check failed");

`endif

FILE: src/msps_pkg.sv
// ----------------------------------------------------------------------------
// Servo sequencer package
// Field widths, reset values, codes and shared types of the servo sequencer.
// ----------------------------------------------------------------------------
package msps_pkg;

    // field widths
    localparam int POS_W     = 15;
    localparam int CHAN_W    = 3;
    localparam int TICK_W    = 8;
    localparam int SLOT_W    = 8;
    localparam int PIN_OUT_W = 5;
    localparam int CFG_IDX_W = 1;

    // defaults and constants
    localparam int             SERVO_COUNT_DEF = 5;
    localparam logic [SLOT_W-1:0] GAP_SLOTS    = 8'd25;
    localparam logic [SLOT_W-1:0] SLOT_RESET   = 8'd1;
    localparam logic [POS_W-1:0]  POS_RESET    = 15'h0400;
    localparam logic [POS_W-1:0]  POS_MIN_RESET = 15'd256;
    localparam logic [POS_W-1:0]  POS_MAX_RESET = 15'd32767;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POS_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_MAX = 1'b1;

    // action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // per-cycle control of the processing stage
    typedef struct packed {
        logic fire;
        logic tick;
        logic write;
    } t_item_ctl;

endpackage

FILE: src/multiplexed_servo_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// Multiplexed servo pulse sequencer
// Input words (tick or position write) enter on a valid/ready channel; each
// word yields one result word (pin levels, read back) on a second one.
// A word passes an input register, then the state update and the result
// register. One word is taken every cycle while not stalled; the rate is set
// by the update of the counters and the two-port position RAM. A full result
// register stalls the input register only when the receiver holds ready low;
// words wait and none is dropped. Configuration writes (position_min,
// position_max) take effect at once and are issued while idle, a rule on the
// user that the block does not enforce. Reset clears counters, pins and all
// valid bits, so every position reads 1024 until written; no clearing pass.
// ----------------------------------------------------------------------------
`include "multiplexed_servo_pulse_sequencer_macros.svh"

module multiplexed_servo_pulse_sequencer #(
    parameter int SERVO_COUNT = msps_pkg::SERVO_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_action,
    input  logic [msps_pkg::CHAN_W-1:0]    i_channel,
    input  logic [msps_pkg::POS_W-1:0]     i_position,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [msps_pkg::PIN_OUT_W-1:0] o_pulse_pins,
    output logic [msps_pkg::POS_W-1:0]     o_position_read,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [msps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [msps_pkg::POS_W-1:0]     i_cfg_data
);

    localparam int ACT_W = $clog2(SERVO_COUNT + 1);
    localparam int PW    = msps_pkg::POS_W;
    localparam int OW    = msps_pkg::PIN_OUT_W;

    logic                        r_in_valid;
    logic                        r_action;
    logic [msps_pkg::CHAN_W-1:0] r_channel;
    logic [PW-1:0]               r_position;
    logic                        r_out_valid;
    logic [OW-1:0]               r_out_pins;
    logic [PW-1:0]               r_out_read;
    logic [PW-1:0]               r_pos_min;
    logic [PW-1:0]               r_pos_max;
    logic                        fire;
    logic                        accept;
    msps_pkg::t_item_ctl         ctl;
    logic [ACT_W-1:0]            active_next;
    logic [SERVO_COUNT-1:0]      pins_next;
    logic [PW-1:0]               active_pos;
    logic [PW-1:0]               readback;
    logic [OW-1:0]               pins_out;

    // handshake
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign accept     = i_in_valid && o_in_ready;

    assign ctl.fire  = fire;
    assign ctl.tick  = (r_action == msps_pkg::ACT_TICK);
    assign ctl.write = (r_action == msps_pkg::ACT_WRITE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_min <= msps_pkg::POS_MIN_RESET;
            r_pos_max <= msps_pkg::POS_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                msps_pkg::CFG_POS_MIN: r_pos_min <= i_cfg_data;
                msps_pkg::CFG_POS_MAX: r_pos_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action   <= i_action;
            r_channel  <= i_channel;
            r_position <= i_position;
        end
    end

    msps_seq #(
        .SERVO_COUNT (SERVO_COUNT)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_active_pos  (active_pos),
        .o_active_next (active_next),
        .o_pins_next   (pins_next)
    );

    msps_store #(
        .SERVO_COUNT (SERVO_COUNT)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_in_channel  (i_channel),
        .i_ctl         (ctl),
        .i_channel     (r_channel),
        .i_position    (r_position),
        .i_pos_min     (r_pos_min),
        .i_pos_max     (r_pos_max),
        .i_active_next (active_next),
        .o_readback    (readback),
        .o_active_pos  (active_pos)
    );

    // map internal pins onto the output width
    for (genvar g = 0; g < OW; g++) begin : g_pin
        if (g < SERVO_COUNT) begin : g_used
            assign pins_out[g] = pins_next[g];
        end else begin : g_unused
            assign pins_out[g] = 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_pins <= pins_out;
            r_out_read <= readback;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pulse_pins    = r_out_pins;
    assign o_position_read = r_out_read;

    // checks
    `MSPS_ASSERT_NEXT(a_held_word_kept, i_clk, i_rst_n, r_in_valid && !fire, r_in_valid)
    `MSPS_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, !o_in_ready, r_out_valid && !i_out_ready)
    `MSPS_ASSERT_ALWAYS(a_one_pin_high, i_clk, i_rst_n, $onehot0(pins_next))

endmodule

FILE: src/msps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module msps_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 5,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re_a,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic             i_re_b,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: src/msps_store.sv
// ----------------------------------------------------------------------------
// Servo position store
// Clamps written positions, keeps them in RAM with per-entry valid bits and
// serves the addressed read back and the active servo's position.
// ----------------------------------------------------------------------------
module msps_store #(
    parameter int SERVO_COUNT = msps_pkg::SERVO_COUNT_DEF,
    localparam int ACT_W  = $clog2(SERVO_COUNT + 1),
    localparam int ADDR_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [msps_pkg::CHAN_W-1:0] i_in_channel,
    input  msps_pkg::t_item_ctl         i_ctl,
    input  logic [msps_pkg::CHAN_W-1:0] i_channel,
    input  logic [msps_pkg::POS_W-1:0]  i_position,
    input  logic [msps_pkg::POS_W-1:0]  i_pos_min,
    input  logic [msps_pkg::POS_W-1:0]  i_pos_max,
    input  logic [ACT_W-1:0]            i_active_next,
    output logic [msps_pkg::POS_W-1:0]  o_readback,
    output logic [msps_pkg::POS_W-1:0]  o_active_pos
);

    localparam int PW    = msps_pkg::POS_W;
    // one bit above the channel code so a full set of eight servos compares
    localparam int CMP_W = msps_pkg::CHAN_W + 1;

    logic [SERVO_COUNT-1:0] r_vld;
    logic [ADDR_W-1:0]      addr_a;
    logic [ADDR_W-1:0]      addr_b;
    logic [ADDR_W-1:0]      waddr;
    logic                   we;
    logic                   stage_in_range;
    logic [PW-1:0]          capped;
    logic [PW-1:0]          clamped;
    logic [PW-1:0]          rdata_a;
    logic [PW-1:0]          rdata_b;
    logic                   r_a_hit;
    logic                   r_a_vld;
    logic [PW-1:0]          r_a_fwd;
    logic                   r_b_hit;
    logic                   r_b_vld;
    logic [PW-1:0]          r_b_fwd;
    logic [PW-1:0]          stored_a;

    // clamp: maximum first, minimum wins
    assign capped  = (i_position > i_pos_max) ? i_pos_max : i_position;
    assign clamped = (capped < i_pos_min) ? i_pos_min : capped;

    // write only in-range channels
    assign stage_in_range = (CMP_W'(i_channel) < CMP_W'(SERVO_COUNT));
    assign we    = i_ctl.fire && i_ctl.write && stage_in_range;
    assign waddr = i_channel[ADDR_W-1:0];

    // read addresses, out-of-range codes fold to entry zero
    assign addr_a = (CMP_W'(i_in_channel) < CMP_W'(SERVO_COUNT)) ?
                    i_in_channel[ADDR_W-1:0] : '0;
    assign addr_b = (i_active_next < ACT_W'(SERVO_COUNT)) ?
                    i_active_next[ADDR_W-1:0] : '0;

    msps_ram #(
        .WIDTH (PW),
        .DEPTH (SERVO_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (clamped),
        .i_re_a    (i_accept),
        .i_raddr_a (addr_a),
        .o_rdata_a (rdata_a),
        .i_re_b    (1'b1),
        .i_raddr_b (addr_b),
        .o_rdata_b (rdata_b)
    );

    // mark written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (we) begin
            r_vld[waddr] <= 1'b1;
        end
    end

    // capture valid bit and forward a same-edge write for each read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_hit <= 1'b0;
            r_a_vld <= 1'b0;
            r_b_hit <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (i_accept) begin
                r_a_hit <= we && (waddr == addr_a);
                r_a_vld <= r_vld[addr_a];
            end
            r_b_hit <= we && (waddr == addr_b);
            r_b_vld <= r_vld[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_fwd <= clamped;
        end
        r_b_fwd <= clamped;
    end

    assign stored_a = r_a_hit ? r_a_fwd : (r_a_vld ? rdata_a : msps_pkg::POS_RESET);
    assign o_active_pos = r_b_hit ? r_b_fwd :
                          (r_b_vld ? rdata_b : msps_pkg::POS_RESET);

    // read back after this item
    always_comb begin
        if (!stage_in_range) begin
            o_readback = '0;
        end else if (we) begin
            o_readback = clamped;
        end else begin
            o_readback = stored_a;
        end
    end

endmodule

FILE: src/msps_seq.sv
// ----------------------------------------------------------------------------
// Servo slot sequencer
// Tick and slot counters, active servo index and pin levels.
// ----------------------------------------------------------------------------
module msps_seq #(
    parameter int SERVO_COUNT = msps_pkg::SERVO_COUNT_DEF,
    localparam int ACT_W  = $clog2(SERVO_COUNT + 1),
    localparam int ADDR_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  msps_pkg::t_item_ctl        i_ctl,
    input  logic [msps_pkg::POS_W-1:0] i_active_pos,
    output logic [ACT_W-1:0]           o_active_next,
    output logic [SERVO_COUNT-1:0]     o_pins_next
);

    localparam int TW = msps_pkg::TICK_W;
    localparam int SW = msps_pkg::SLOT_W;

    logic [TW-1:0]          r_tick;
    logic [TW-1:0]          n_tick;
    logic [SW-1:0]          r_slot;
    logic [SW-1:0]          n_slot;
    logic [ACT_W-1:0]       r_active;
    logic [ACT_W-1:0]       n_active;
    logic [SERVO_COUNT-1:0] r_pins;
    logic [SERVO_COUNT-1:0] n_pins;
    logic [TW-1:0]          tick_inc;
    logic [SW-1:0]          slot_dec;
    logic [ACT_W-1:0]       prev_active;
    logic [TW-1:0]          pos_low;
    logic [SW-1:0]          pos_slots;

    assign tick_inc    = r_tick + TW'(1);
    assign slot_dec    = r_slot - SW'(1);
    assign prev_active = r_active - ACT_W'(1);
    assign pos_low     = i_active_pos[TW-1:0];
    assign pos_slots   = SW'(i_active_pos[msps_pkg::POS_W-1:TW]);

    // advance counters on a tick item
    always_comb begin
        n_tick   = r_tick;
        n_slot   = r_slot;
        n_active = r_active;
        n_pins   = r_pins;
        if (i_ctl.fire && i_ctl.tick) begin
            n_tick = tick_inc;
            if (tick_inc == '0) begin
                n_slot = slot_dec;
                // slot expired: zero or negative
                if ((slot_dec == '0) || slot_dec[SW-1]) begin
                    if (r_active < ACT_W'(SERVO_COUNT)) begin
                        if (r_active != '0) begin
                            n_pins[prev_active[ADDR_W-1:0]] = 1'b0;
                        end
                        n_pins[r_active[ADDR_W-1:0]] = 1'b1;
                        if (pos_low != '0) begin
                            n_tick = TW'(0) - pos_low;
                            n_slot = pos_slots;
                        end else begin
                            n_tick = '0;
                            n_slot = pos_slots - SW'(1);
                        end
                        n_active = r_active + ACT_W'(1);
                    end else begin
                        // gap after the last servo
                        n_pins[SERVO_COUNT-1] = 1'b0;
                        n_slot   = msps_pkg::GAP_SLOTS;
                        n_active = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_slot   <= msps_pkg::SLOT_RESET;
            r_active <= '0;
            r_pins   <= '0;
        end else begin
            r_tick   <= n_tick;
            r_slot   <= n_slot;
            r_active <= n_active;
            r_pins   <= n_pins;
        end
    end

    assign o_active_next = n_active;
    assign o_pins_next   = n_pins;

endmodule
